FILE: src/lcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_pkg: shared types and constants
// Commands, status codes, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
package lcc_pkg;

   localparam logic [19:0] MIDSCALE = 20'h7FFFF;
   localparam logic [31:0] FOUR_MA  = 32'd262144;

   localparam logic [19:0] DEF_CODE_MIN = 20'h00000;
   localparam logic [19:0] DEF_CODE_MID = 20'h80000;
   localparam logic [19:0] DEF_CODE_MAX = 20'hFFFFF;
   localparam logic [31:0] DEF_CUR_MIN  = 32'd0;
   localparam logic [31:0] DEF_CUR_MID  = 32'd655360;
   localparam logic [31:0] DEF_CUR_MAX  = 32'd1310720;

   localparam logic CMD_CONVERT = 1'b0;
   localparam logic CMD_LOAD    = 1'b1;

   localparam logic [1:0] MODE_4_20 = 2'd0;

   localparam logic [1:0] PT_MIN    = 2'd0;
   localparam logic [1:0] PT_MID    = 2'd1;
   localparam logic [1:0] PT_MAX    = 2'd2;
   localparam logic [1:0] PT_UNUSED = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_UNDER     = 3'd1;
   localparam logic [2:0] ST_ZERO_SPAN = 3'd2;
   localparam logic [2:0] ST_RAW       = 3'd3;
   localparam logic [2:0] ST_LOAD      = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLAMP,
      S_FETCH,
      S_SETUP,
      S_MUL,
      S_DIV,
      S_MEAS,
      S_ENG,
      S_PROD,
      S_FINISH,
      S_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic clamp;
      logic fetch;
      logic setup;
      logic mul;
      logic div_step;
      logic meas;
      logic eng;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_load;
      logic raw_only;
      logic zero_code;
      logic zero_span;
      logic div_done;
   } stat_type;

endpackage

FILE: src/lcc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_req_if / lcc_rsp_if: request and response channels
// Valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface lcc_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic [2:0]         channel;
   logic [23:0]        raw_code;
   logic               hw_range_is_0_20;
   logic [1:0]         range_mode;
   logic signed [31:0] scale_low;
   logic signed [31:0] scale_high;
   logic signed [31:0] scale_offset;
   logic [1:0]         point_select;
   logic [19:0]        point_code;
   logic signed [31:0] point_current;

   modport source (output valid, command, channel, raw_code, hw_range_is_0_20,
                   range_mode, scale_low, scale_high, scale_offset, point_select,
                   point_code, point_current, input ready);
   modport sink (input valid, command, channel, raw_code, hw_range_is_0_20,
                 range_mode, scale_low, scale_high, scale_offset, point_select,
                 point_code, point_current, output ready);
endinterface

interface lcc_rsp_if;
   logic               valid;
   logic               ready;
   logic [19:0]        binary_value;
   logic signed [31:0] measured_current;
   logic signed [31:0] span_fraction;
   logic signed [31:0] engineering_value;
   logic [2:0]         status;

   modport source (output valid, binary_value, measured_current, span_fraction,
                   engineering_value, status, input ready);
   modport sink (input valid, binary_value, measured_current, span_fraction,
                 engineering_value, status, output ready);
endinterface

FILE: src/lcc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_ctrl: sequencing controller
// Steps one item through clamp, fetch, multiply, divide and scaling.
// ----------------------------------------------------------------------------
module lcc_ctrl
   import lcc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CLAMP;
            end
         end
         S_CLAMP: begin
            // load and raw-only items finish here
            if (stat.is_load || stat.raw_only) begin
               state_in = S_OUT;
            end else begin
               cmd.clamp = 1'b1;
               state_in  = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_SETUP;
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            if (stat.zero_code || stat.zero_span) begin
               state_in = S_MEAS;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = S_MEAS;
            end
         end
         S_MEAS: begin
            cmd.meas = 1'b1;
            state_in = S_ENG;
         end
         S_ENG: begin
            cmd.eng  = 1'b1;
            state_in = S_PROD;
         end
         S_PROD: begin
            // engineering product settles in its register
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: src/lcc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_datapath: calibration table and arithmetic
// Table store, clamp compare, interpolation with a radix-2 divider, scaling.
// ----------------------------------------------------------------------------
module lcc_datapath
   import lcc_pkg::*;
#(
   parameter int CHANNELS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic               command,
   input  logic [2:0]         channel,
   input  logic [23:0]        raw_code,
   input  logic               hw_range_is_0_20,
   input  logic [1:0]         range_mode,
   input  logic signed [31:0] scale_low,
   input  logic signed [31:0] scale_high,
   input  logic signed [31:0] scale_offset,
   input  logic [1:0]         point_select,
   input  logic [19:0]        point_code,
   input  logic signed [31:0] point_current,
   output logic [19:0]        binary_value,
   output logic signed [31:0] measured_current,
   output logic signed [31:0] span_fraction,
   output logic signed [31:0] engineering_value,
   output logic [2:0]         status
);

   localparam int ENTRIES = 3 * CHANNELS;
   localparam int QW      = 53;   // 21x32 product magnitude
   localparam int DCNT_W  = $clog2(QW + 1);

   // table: flops with per-entry written bit, unwritten entries read default
   logic [19:0] codes_ff    [ENTRIES];
   logic [31:0] currents_ff [ENTRIES];
   logic [ENTRIES-1:0] written_ff;

   // captured item
   logic        is_load_ff, raw_ff, hw_ff;
   logic [4:0]  base_ff;
   logic [19:0] code_ff;
   logic signed [31:0] lo_ff, hi_ff, off_ff;

   // segment data
   logic signed [31:0] i0_ff;
   logic signed [21:0] dc_ff, den_ff;
   logic signed [32:0] di_ff;
   logic        zspan_ff, neg_ff;
   logic [20:0] mden_ff;
   logic [QW-1:0] prod_ff, quot_ff;
   logic [21:0]   rem_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic signed [31:0] meas_ff;
   logic [31:0] above_ff;
   logic signed [32:0] dspan_ff;
   logic [63:0] emag_ff;
   logic [2:0]  status_ff;
   logic signed [31:0] frac_ff, eng_ff;

   function automatic logic [19:0] def_code(input logic [1:0] p);
      case (p)
         PT_MIN:  return DEF_CODE_MIN;
         PT_MID:  return DEF_CODE_MID;
         default: return DEF_CODE_MAX;
      endcase
   endfunction

   function automatic logic [31:0] def_cur(input logic [1:0] p);
      case (p)
         PT_MIN:  return DEF_CUR_MIN;
         PT_MID:  return DEF_CUR_MID;
         default: return DEF_CUR_MAX;
      endcase
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [45:0] v);
      if (v > 46'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -46'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   logic [4:0] idx_mid, idx_k0, idx_k1;
   logic       seg_hi;
   logic [1:0] pt_k0, pt_k1;
   logic [19:0] c_mid, c_k0, c_k1;
   logic [31:0] i_mid, i_k0, i_k1;

   assign seg_hi  = code_ff > MIDSCALE;
   assign idx_mid = base_ff + 5'd1;
   assign idx_k0  = base_ff + {4'd0, seg_hi};
   assign idx_k1  = idx_k0 + 5'd1;
   assign pt_k0   = seg_hi ? PT_MID : PT_MIN;
   assign pt_k1   = seg_hi ? PT_MAX : PT_MID;

   assign c_mid = written_ff[idx_mid] ? codes_ff[idx_mid] : DEF_CODE_MID;
   assign i_mid = written_ff[idx_mid] ? currents_ff[idx_mid] : DEF_CUR_MID;
   assign c_k0  = written_ff[idx_k0] ? codes_ff[idx_k0] : def_code(pt_k0);
   assign c_k1  = written_ff[idx_k1] ? codes_ff[idx_k1] : def_code(pt_k1);
   assign i_k0  = written_ff[idx_k0] ? currents_ff[idx_k0] : def_cur(pt_k0);
   assign i_k1  = written_ff[idx_k1] ? currents_ff[idx_k1] : def_cur(pt_k1);

   logic [51:0] clamp_lhs, clamp_rhs;
   assign clamp_lhs = {32'd0, code_ff} * {20'd0, i_mid};
   assign clamp_rhs = {14'd0, c_mid, 18'd0};

   logic [21:0] rem_sh;
   logic [21:0] rem_sub;
   assign rem_sh  = {rem_ff[20:0], prod_ff[QW-1]};
   assign rem_sub = rem_sh - {1'b0, mden_ff};

   logic [4:0] wr_idx;
   assign wr_idx = 5'(channel) * 5'd3 + {3'd0, point_select};

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (cmd.capture && command == CMD_LOAD
                   && 32'(channel) < CHANNELS && point_select != PT_UNUSED) begin
         written_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture && command == CMD_LOAD
          && 32'(channel) < CHANNELS && point_select != PT_UNUSED) begin
         codes_ff[wr_idx]    <= point_code;
         currents_ff[wr_idx] <= point_current;
      end
   end

   logic [32:0] mdi;
   logic [21:0] mdc;
   assign mdi = di_ff[32] ? 33'(-di_ff) : 33'(di_ff);
   assign mdc = dc_ff[21] ? 22'(-dc_ff) : 22'(dc_ff);

   logic signed [34:0] meas_sum;
   logic signed [QW:0] delta;
   assign delta    = neg_ff ? -$signed({1'b0, quot_ff}) : $signed({1'b0, quot_ff});

   always_comb begin
      if (delta > 54'sd4294967296) meas_sum = 35'sd4294967296;
      else if (delta < -54'sd4294967296) meas_sum = -35'sd4294967296;
      else meas_sum = 35'(delta);
      meas_sum = meas_sum + 35'(i0_ff);
   end

   logic [31:0] dmag;
   assign dmag = dspan_ff[32] ? 32'(-dspan_ff) : 32'(dspan_ff);
   logic signed [44:0] sp;
   assign sp = dspan_ff[32] ? -$signed({1'b0, emag_ff[63:20]})
                            : $signed({1'b0, emag_ff[63:20]});
   logic signed [45:0] eng_sum;
   assign eng_sum = 46'(sp) + 46'(lo_ff) + 46'(off_ff);
   logic signed [34:0] base_sum;
   assign base_sum = 35'(lo_ff) + 35'(off_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         is_load_ff <= (command == CMD_LOAD);
         raw_ff     <= (range_mode != MODE_4_20) || (32'(channel) >= CHANNELS);
         hw_ff      <= hw_range_is_0_20;
         base_ff    <= 5'(channel) * 5'd3;
         code_ff    <= raw_code[23:4];
         lo_ff      <= scale_low;
         hi_ff      <= scale_high;
         off_ff     <= scale_offset;
         meas_ff    <= '0;
         frac_ff    <= '0;
         eng_ff     <= '0;
         status_ff  <= (command == CMD_LOAD) ? ST_LOAD : ST_RAW;
      end
      if (cmd.clamp) begin
         if (hw_ff && !i_mid[31] && i_mid != 32'd0 && clamp_lhs < clamp_rhs) begin
            code_ff <= '0;
         end
      end
      if (cmd.fetch) begin
         i0_ff    <= i_k0;
         dc_ff    <= $signed({2'b0, code_ff}) - $signed({2'b0, c_k0});
         den_ff   <= $signed({2'b0, c_k1}) - $signed({2'b0, c_k0});
         di_ff    <= 33'(signed'(i_k1)) - 33'(signed'(i_k0));
      end
      if (cmd.setup) begin
         zspan_ff <= (code_ff != 20'd0) && (den_ff == 22'sd0);
         neg_ff   <= ((dc_ff < 0) != (di_ff < 0)) != (den_ff < 0);
         mden_ff  <= den_ff[21] ? 21'(-den_ff) : 21'(den_ff);
      end
      if (cmd.mul) begin
         prod_ff <= QW'(mdc[20:0] * mdi[31:0]) | (mdi[32] ? QW'({mdc[20:0], 32'd0}) : '0);
         quot_ff <= '0;
         rem_ff  <= '0;
         dcnt_ff <= DCNT_W'(QW);
      end else if (cmd.div_step) begin
         prod_ff <= {prod_ff[QW-2:0], 1'b0};
         dcnt_ff <= dcnt_ff - 1'b1;
         if (!rem_sub[21]) begin
            rem_ff  <= rem_sub;
            quot_ff <= {quot_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            quot_ff <= {quot_ff[QW-2:0], 1'b0};
         end
      end
      if (cmd.meas) begin
         if (code_ff == 20'd0) meas_ff <= '0;
         else if (zspan_ff) meas_ff <= i0_ff;
         else meas_ff <= sat32(46'(meas_sum));
      end
      if (cmd.eng) begin
         above_ff <= 32'(meas_ff) - FOUR_MA;
         dspan_ff <= 33'(hi_ff) - 33'(lo_ff);
      end
      if (cmd.finish) begin
         if (zspan_ff) begin
            frac_ff   <= '0;
            eng_ff    <= sat32(46'(base_sum));
            status_ff <= ST_ZERO_SPAN;
         end else if (meas_ff >= $signed(FOUR_MA)) begin
            frac_ff   <= {4'd0, above_ff[31:4]};
            eng_ff    <= sat32(eng_sum);
            status_ff <= ST_OK;
         end else begin
            frac_ff   <= '0;
            eng_ff    <= sat32(46'(base_sum));
            status_ff <= ST_UNDER;
         end
      end
   end

   // engineering product, registered before use
   always_ff @(posedge clock) begin
      emag_ff <= 64'(dmag) * 64'(above_ff);
   end

   assign stat.is_load   = is_load_ff;
   assign stat.raw_only  = raw_ff;
   assign stat.zero_code = (code_ff == 20'd0);
   assign stat.zero_span = (den_ff == 22'sd0);
   assign stat.div_done  = (dcnt_ff == DCNT_W'(1));

   assign binary_value      = is_load_ff ? 20'd0 : code_ff;
   assign measured_current  = meas_ff;
   assign span_fraction     = frac_ff;
   assign engineering_value = eng_ff;
   assign status            = status_ff;

endmodule

FILE: src/loop_current_calibrator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loop_current_calibrator_core: two-segment 4-20 mA calibrator
// Per-channel three-point table, interpolation and engineering scaling.
// ----------------------------------------------------------------------------
// One item at a time. A load or raw-only item goes from the clamp state
// straight to the response; a convert item runs the 53-step restoring
// divider of the interpolation, or skips it when the code is zero or the
// segment span is zero. After the response transfer the block can take the
// next request in the following cycle. The table resets to the defaults
// (min 0x00000/0 mA, middle 0x80000/10 mA, max 0xFFFFF/20 mA) at once.
module loop_current_calibrator_core
   import lcc_pkg::*;
#(
   parameter int CHANNELS = 8
) (
   input logic     clock,
   input logic     reset,
   lcc_req_if.sink   req,
   lcc_rsp_if.source rsp
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   lcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table and arithmetic
   lcc_datapath #(.CHANNELS(CHANNELS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .command           (req.command),
      .channel           (req.channel),
      .raw_code          (req.raw_code),
      .hw_range_is_0_20  (req.hw_range_is_0_20),
      .range_mode        (req.range_mode),
      .scale_low         (req.scale_low),
      .scale_high        (req.scale_high),
      .scale_offset      (req.scale_offset),
      .point_select      (req.point_select),
      .point_code        (req.point_code),
      .point_current     (req.point_current),
      .binary_value      (rsp.binary_value),
      .measured_current  (rsp.measured_current),
      .span_fraction     (rsp.span_fraction),
      .engineering_value (rsp.engineering_value),
      .status            (rsp.status)
   );

endmodule

FILE: tb/sv/tb_loop_current_calibrator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_loop_current_calibrator_core: self-checking bench for the calibrator
// Directed and random load/convert transfers with random idling on both
// sides. A local table and interpolation predict every response in order.
// ----------------------------------------------------------------------------
module tb_loop_current_calibrator_core;
   import lcc_pkg::*;

   // request fields as one record
   typedef struct {
      logic               command;
      logic [2:0]         channel;
      logic [23:0]        raw_code;
      logic               hw_range_is_0_20;
      logic [1:0]         range_mode;
      logic signed [31:0] scale_low;
      logic signed [31:0] scale_high;
      logic signed [31:0] scale_offset;
      logic [1:0]         point_select;
      logic [19:0]        point_code;
      logic signed [31:0] point_current;
   } cal_item_type;

   typedef struct {
      logic [19:0]        binary_value;
      logic signed [31:0] measured_current;
      logic signed [31:0] span_fraction;
      logic signed [31:0] engineering_value;
      logic [2:0]         status;
   } reading_type;

   localparam int NUM_CH      = 8;
   localparam int CYCLE_LIMIT = 1500000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lcc_req_if req ();
   lcc_rsp_if rsp ();

   loop_current_calibrator_core #(.CHANNELS(NUM_CH)) dut (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source)
   );

   always #4 clock = ~clock;

   cal_item_type pending_items[$];
   reading_type  expected_readings[$];

   // predictor copy of the calibration table
   logic [19:0]        table_code[3*NUM_CH];
   logic signed [31:0] table_current[3*NUM_CH];

   int  mismatches = 0;
   int  cycle_count = 0;
   bit  stimulus_done = 1'b0;
   bit  hold_off_request = 1'b0;
   int  hold_off_left = 0;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'h7FFFFFFF;
      if (v < -66'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   task automatic reset_table();
      for (int c = 0; c < NUM_CH; c++) begin
         table_code[c*3]      = DEF_CODE_MIN;
         table_code[c*3+1]    = DEF_CODE_MID;
         table_code[c*3+2]    = DEF_CODE_MAX;
         table_current[c*3]   = DEF_CUR_MIN;
         table_current[c*3+1] = DEF_CUR_MID;
         table_current[c*3+2] = DEF_CUR_MAX;
      end
   endtask

   // expected response for one accepted transfer; updates the table on loads
   function automatic reading_type calibrate(input cal_item_type it);
      reading_type r;
      logic [19:0] code;
      int b, k;
      logic signed [65:0] c0, c1, i0, i1, den, dc, di, q, delta;
      logic signed [65:0] lo, hi, off, dspan, above, p;
      logic [63:0] lhs, rhs;
      bit zspan;
      r = '{default: '0};
      lo = it.scale_low;
      hi = it.scale_high;
      off = it.scale_offset;
      code = it.raw_code[23:4];
      zspan = 0;
      if (it.command == CMD_LOAD) begin
         if (it.point_select != PT_UNUSED) begin
            table_code[it.channel*3 + it.point_select]    = it.point_code;
            table_current[it.channel*3 + it.point_select] = it.point_current;
         end
         r.status = ST_LOAD;
         return r;
      end
      if (it.range_mode != MODE_4_20) begin
         r.binary_value = code;
         r.status = ST_RAW;
         return r;
      end
      b = it.channel * 3;
      // under-range clamp on 0-20 mA hardware
      if (it.hw_range_is_0_20 && table_current[b+1] > 0) begin
         lhs = 64'(code) * 64'(unsigned'(table_current[b+1]));
         rhs = 64'(table_code[b+1]) << 18;
         if (lhs < rhs) code = '0;
      end
      if (code != 0) begin
         k = (code <= MIDSCALE) ? 0 : 1;
         c0 = $signed({1'b0, table_code[b+k]});
         c1 = $signed({1'b0, table_code[b+k+1]});
         i0 = table_current[b+k];
         i1 = table_current[b+k+1];
         den = c1 - c0;
         if (den == 0) begin
            zspan = 1;
            r.measured_current = i0[31:0];
         end else begin
            dc = $signed({1'b0, code}) - c0;
            di = i1 - i0;
            q = (dc * di) / den;   // SV division truncates toward zero
            delta = q;
            r.measured_current = sat32(i0 + delta);
         end
      end
      if (zspan) begin
         r.engineering_value = sat32(lo + off);
         r.status = ST_ZERO_SPAN;
      end else if (r.measured_current >= $signed(FOUR_MA)) begin
         above = r.measured_current - $signed(FOUR_MA);
         dspan = hi - lo;
         p = dspan * above;
         p = (p < 0) ? -((-p) >>> 20) : (p >>> 20);
         r.span_fraction = above[35:4];
         r.engineering_value = sat32(p + lo + off);
         r.status = ST_OK;
      end else begin
         r.engineering_value = sat32(lo + off);
         r.status = ST_UNDER;
      end
      r.binary_value = code;
      return r;
   endfunction

   function automatic cal_item_type random_item();
      cal_item_type it;
      it.command          = ($urandom_range(0, 3) == 0) ? CMD_LOAD : CMD_CONVERT;
      it.channel          = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 4))
         0: it.raw_code = 24'($urandom_range(0, 15));
         1: it.raw_code = 24'(24'h7FFFF0 + $urandom_range(0, 31));
         2: it.raw_code = 24'(24'hFFFFF0 | $urandom_range(0, 15));
         default: it.raw_code = 24'($urandom);
      endcase
      it.hw_range_is_0_20 = 1'($urandom_range(0, 1));
      it.range_mode       = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(1, 3))
                                                       : MODE_4_20;
      it.scale_low        = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200000);
      it.scale_high       = ($urandom_range(0, 3) == 0) ? $urandom
                                                       : $urandom_range(0, 9000000);
      it.scale_offset     = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
      it.point_select     = ($urandom_range(0, 9) == 0) ? PT_UNUSED
                                                       : 2'($urandom_range(0, 2));
      // keep most tables well formed so the convert path is exercised deeply
      case (it.point_select)
         PT_MIN: it.point_code = 20'($urandom_range(0, 20000));
         PT_MID: it.point_code = 20'($urandom_range(400000, 650000));
         default: it.point_code = 20'($urandom_range(1000000, 1048575));
      endcase
      if ($urandom_range(0, 7) == 0) it.point_code = 20'($urandom);
      it.point_current    = (it.point_select * 655360) + $signed($urandom_range(0, 131072))
                            - 65536;
      if ($urandom_range(0, 7) == 0) it.point_current = $urandom;
      return it;
   endfunction

   function automatic cal_item_type make_item(input logic cmd, input int ch,
                                              input logic [23:0] raw,
                                              input logic hw, input logic [1:0] mode,
                                              input logic [1:0] psel,
                                              input logic [19:0] pcode,
                                              input logic signed [31:0] pcur);
      cal_item_type it;
      it = random_item();
      it.command = cmd; it.channel = 3'(ch); it.raw_code = raw;
      it.hw_range_is_0_20 = hw; it.range_mode = mode;
      it.point_select = psel; it.point_code = pcode; it.point_current = pcur;
      return it;
   endfunction

   // stimulus: directed corners first, then random traffic
   initial begin
      cal_item_type it;
      reset_table();
      pending_items.push_back(make_item(CMD_CONVERT, 0, 24'h000000, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(CMD_CONVERT, 1, 24'hFFFFFF, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(CMD_CONVERT, 2, 24'h7FFFF0, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(CMD_CONVERT, 2, 24'h800000, 1, 0, 0, 0, 0));
      pending_items.push_back(make_item(CMD_CONVERT, 3, 24'h010000, 1, 0, 0, 0, 0));
      pending_items.push_back(make_item(CMD_CONVERT, 3, 24'h123456, 0, 1, 0, 0, 0));
      pending_items.push_back(make_item(CMD_CONVERT, 3, 24'h123456, 0, 2, 0, 0, 0));
      pending_items.push_back(make_item(CMD_CONVERT, 3, 24'hABCDEF, 0, 3, 0, 0, 0));
      pending_items.push_back(make_item(CMD_LOAD, 4, 0, 0, 0, PT_UNUSED, 20'hFFFFF,
                                        32'h7FFFFFFF));
      // zero span: min and middle codes equal
      pending_items.push_back(make_item(CMD_LOAD, 4, 0, 0, 0, PT_MID, 20'h00000, 32'sd300000));
      pending_items.push_back(make_item(CMD_CONVERT, 4, 24'h100000, 0, 0, 0, 0, 0));
      // reversed segment
      pending_items.push_back(make_item(CMD_LOAD, 5, 0, 0, 0, PT_MIN, 20'hFFFFF, 32'h80000000));
      pending_items.push_back(make_item(CMD_CONVERT, 5, 24'h400000, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(CMD_LOAD, 6, 0, 0, 0, PT_MAX, 20'hFFFFF, 32'h7FFFFFFF));
      pending_items.push_back(make_item(CMD_CONVERT, 6, 24'hFFFFFF, 0, 0, 0, 0, 0));
      // middle current not positive disables the clamp
      pending_items.push_back(make_item(CMD_LOAD, 7, 0, 0, 0, PT_MID, 20'h80000, 32'sd0));
      pending_items.push_back(make_item(CMD_CONVERT, 7, 24'h000010, 1, 0, 0, 0, 0));
      it = make_item(CMD_CONVERT, 1, 24'hC00000, 0, 0, 0, 0, 0);
      it.scale_low = 32'h80000000; it.scale_high = 32'h7FFFFFFF; it.scale_offset = 32'h7FFFFFFF;
      pending_items.push_back(it);
      it.scale_low = 32'h7FFFFFFF; it.scale_high = 32'h80000000; it.scale_offset = 32'h80000000;
      pending_items.push_back(it);
      for (int n = 0; n < 1750; n++) pending_items.push_back(random_item());
   end

   // reset and clock-count watchdog
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("loop_current_calibrator_core verification failed");
         $finish;
      end
   end

   // driver: one transfer per item, random gap drawn per item
   int send_gap = 0;
   int sent = 0;
   initial begin
      req.valid = 1'b0;
      req.command = CMD_CONVERT; req.channel = '0; req.raw_code = '0;
      req.hw_range_is_0_20 = 1'b0; req.range_mode = '0; req.scale_low = '0;
      req.scale_high = '0; req.scale_offset = '0; req.point_select = '0;
      req.point_code = '0; req.point_current = '0;
      rsp.ready = 1'b0;
   end

   always @(posedge clock) begin
      cal_item_type it;
      if (!reset) begin
         if (req.valid && req.ready) begin
            expected_readings.push_back(calibrate(pending_items.pop_front()));
            sent <= sent + 1;
            // long receiver hold-off after the 41st request transfer
            if (sent == 40) hold_off_request <= 1'b1;
            send_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
         end
         if (req.valid && !req.ready) begin
            // keep offering
         end else if (send_gap > 0) begin
            send_gap--;
            req.valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            it = pending_items[0];
            req.valid            <= 1'b1;
            req.command          <= it.command;
            req.channel          <= it.channel;
            req.raw_code         <= it.raw_code;
            req.hw_range_is_0_20 <= it.hw_range_is_0_20;
            req.range_mode       <= it.range_mode;
            req.scale_low        <= it.scale_low;
            req.scale_high       <= it.scale_high;
            req.scale_offset     <= it.scale_offset;
            req.point_select     <= it.point_select;
            req.point_code       <= it.point_code;
            req.point_current    <= it.point_current;
         end else begin
            req.valid <= 1'b0;
            stimulus_done <= 1'b1;
         end
      end
   end

   // receiver: random stalls per response, plus one long hold-off
   int recv_gap = 0;
   always @(posedge clock) begin
      reading_type got, want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.binary_value, rsp.measured_current, rsp.span_fraction,
                    rsp.engineering_value, rsp.status};
            if (expected_readings.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response status %0d", got.status);
            end else begin
               want = expected_readings.pop_front();
               if (got != want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp %h %h %h %h %0d got %h %h %h %h %0d",
                              want.binary_value, want.measured_current, want.span_fraction,
                              want.engineering_value, want.status, got.binary_value,
                              got.measured_current, got.span_fraction,
                              got.engineering_value, got.status);
               end
            end
            recv_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
         end
         if (hold_off_request && hold_off_left == 0) begin
            hold_off_left = 400;
            hold_off_request <= 1'b0;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // end of run: drain, then a short quiet window
   initial begin
      wait (stimulus_done && expected_readings.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_readings.size() == 0) begin
         $display("loop_current_calibrator_core verification clean");
      end else begin
         $display("loop_current_calibrator_core verification failed");
      end
      $finish;
   end

endmodule
